[rtl/core/qmr_pkg.sv]
// qmr_pkg: shared widths, component types and product term tables
// for the quaternion multiply and rotate unit; no dependencies
package qmr_pkg;

	// component format, two's complement with fraction bits
	localparam int CW = 16;
	localparam int FB = 14;
	// widened component, holds the negated vector part of a conjugate
	localparam int WCW = CW + 1;
	// exact product, rounded product, and sum of four rounded terms
	localparam int PW = CW + WCW;
	localparam int NW = PW - FB;
	localparam int SW = NW + 3;

	// component slots, x in the lowest slot
	localparam int NCOMP = 4;
	localparam int CX = 0;
	localparam int CY = 1;
	localparam int CZ = 2;
	localparam int CW_IDX = 3;

	// command codes carried in tuser
	localparam logic CMD_MULTIPLY = 1'b0;
	localparam logic CMD_ROTATE   = 1'b1;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [WCW-1:0] wcomp_t;
	typedef comp_t [NCOMP-1:0] quat_t;
	typedef wcomp_t [NCOMP-1:0] wquat_t;

	// hamilton product terms: for output component j, term k multiplies
	// left[L_IDX[j][k]] by right[R_IDX[j][k]], subtracted where T_NEG is set
	localparam logic [1:0] L_IDX [NCOMP][NCOMP] = '{
		'{2'd3, 2'd0, 2'd1, 2'd2},
		'{2'd3, 2'd0, 2'd1, 2'd2},
		'{2'd3, 2'd0, 2'd1, 2'd2},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] R_IDX [NCOMP][NCOMP] = '{
		'{2'd0, 2'd3, 2'd2, 2'd1},
		'{2'd1, 2'd2, 2'd3, 2'd0},
		'{2'd2, 2'd1, 2'd0, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic T_NEG [NCOMP][NCOMP] = '{
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b1, 1'b1, 1'b1}
	};

	// clip flags of one product, one per component
	typedef logic [NCOMP-1:0] clip_t;

endpackage

[rtl/core/qmr_hprod.sv]
// qmr_hprod: three-stage pipelined fixed point hamilton product
// depends on qmr_pkg for widths, types and the term tables
module qmr_hprod (
	input  logic           clk,
	input  logic           en,
	input  qmr_pkg::quat_t  l,
	input  qmr_pkg::wquat_t r,
	output qmr_pkg::quat_t  o,
	output qmr_pkg::clip_t  clip
);

	localparam logic signed [qmr_pkg::PW-1:0] HALF =
		qmr_pkg::PW'(1) <<< (qmr_pkg::FB - 1);
	localparam logic signed [qmr_pkg::SW-1:0] SMAX =
		{{(qmr_pkg::SW - qmr_pkg::CW + 1){1'b0}}, {(qmr_pkg::CW - 1){1'b1}}};
	localparam logic signed [qmr_pkg::SW-1:0] SMIN = ~SMAX;

	logic signed [qmr_pkg::PW-1:0] prod_d  [qmr_pkg::NCOMP][qmr_pkg::NCOMP];
	logic signed [qmr_pkg::PW-1:0] prod_s1 [qmr_pkg::NCOMP][qmr_pkg::NCOMP];
	logic signed [qmr_pkg::NW-1:0] rnd_d   [qmr_pkg::NCOMP][qmr_pkg::NCOMP];
	logic signed [qmr_pkg::NW-1:0] rnd_s2  [qmr_pkg::NCOMP][qmr_pkg::NCOMP];
	qmr_pkg::quat_t                res_d;
	qmr_pkg::clip_t                clip_d;
	qmr_pkg::quat_t                res_s3;
	qmr_pkg::clip_t                clip_s3;

	// stage 1: sixteen exact products
	always_comb begin
		logic signed [qmr_pkg::PW-1:0] lo;
		logic signed [qmr_pkg::PW-1:0] ro;
		for (int j = 0; j < qmr_pkg::NCOMP; j++) begin
			for (int k = 0; k < qmr_pkg::NCOMP; k++) begin
				lo = qmr_pkg::PW'(l[qmr_pkg::L_IDX[j][k]]);
				ro = qmr_pkg::PW'(r[qmr_pkg::R_IDX[j][k]]);
				prod_d[j][k] = lo * ro;
			end
		end
	end

	// stage 2: round each product to nearest, ties up
	always_comb begin
		logic signed [qmr_pkg::PW-1:0] biased;
		for (int j = 0; j < qmr_pkg::NCOMP; j++) begin
			for (int k = 0; k < qmr_pkg::NCOMP; k++) begin
				biased = prod_s1[j][k] + HALF;
				rnd_d[j][k] = biased[qmr_pkg::PW-1:qmr_pkg::FB];
			end
		end
	end

	// stage 3: signed sum of four terms, then clip to component range
	always_comb begin
		logic signed [qmr_pkg::SW-1:0] sum;
		logic signed [qmr_pkg::SW-1:0] term;
		for (int j = 0; j < qmr_pkg::NCOMP; j++) begin
			sum = '0;
			for (int k = 0; k < qmr_pkg::NCOMP; k++) begin
				term = qmr_pkg::SW'(rnd_s2[j][k]);
				if (qmr_pkg::T_NEG[j][k]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > SMAX) begin
				res_d[j]  = qmr_pkg::comp_t'(SMAX[qmr_pkg::CW-1:0]);
				clip_d[j] = 1'b1;
			end else if (sum < SMIN) begin
				res_d[j]  = qmr_pkg::comp_t'(SMIN[qmr_pkg::CW-1:0]);
				clip_d[j] = 1'b1;
			end else begin
				res_d[j]  = sum[qmr_pkg::CW-1:0];
				clip_d[j] = 1'b0;
			end
		end
	end

	// pipeline registers, advance together on enable
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			rnd_s2  <= rnd_d;
			res_s3  <= res_d;
			clip_s3 <= clip_d;
		end
	end

	assign o    = res_s3;
	assign clip = clip_s3;

endmodule

[rtl/core/quaternion_multiply_rotate_unit.sv]
// quaternion_multiply_rotate_unit: top level, stream ports and pass control
// depends on qmr_pkg and on two instances of qmr_hprod

// Takes one word per cycle while the output side does not stall, and returns
// one result word for each accepted item. Two three-stage
// hamilton product pipelines sit in series: the first forms a*b (multiply)
// or a*v (rotate), the second forms p*conj(a) for rotate while a multiply
// result rides alongside it. The whole pipeline holds when the output word
// is not taken, so s_axis_tready follows m_axis_tready whenever the last
// stage is full. Components are Q1.14; each product is rounded to nearest
// with ties upward, sums are clipped to range, and tuser on the output flags
// any clip, including one in the rotate intermediate.
module quaternion_multiply_rotate_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up
	input  logic [127:0] s_axis_tdata,
	// cmd: 0 multiply, 1 rotate
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// r_x, r_y, r_z, r_w from the lowest bit up
	output logic [63:0]  m_axis_tdata,
	// saturated
	output logic [0:0]   m_axis_tuser
);

	localparam int NC = qmr_pkg::NCOMP;
	localparam int QB = NC * qmr_pkg::CW;

	logic            en;
	logic [6:1]      valid_q;
	qmr_pkg::quat_t  a_in;
	qmr_pkg::quat_t  b_in;
	qmr_pkg::wquat_t r1;
	qmr_pkg::quat_t  p;
	qmr_pkg::clip_t  clip1;
	qmr_pkg::wquat_t ac;
	qmr_pkg::quat_t  rot;
	qmr_pkg::clip_t  clip2;
	logic            cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	qmr_pkg::quat_t  a_s1, a_s2, a_s3;
	qmr_pkg::quat_t  mul_s4, mul_s5, mul_s6;
	logic            flag1_s4, flag1_s5, flag1_s6;
	qmr_pkg::quat_t  res;
	logic            sat_out;

	// whole pipeline advances unless the output word is held
	assign en            = !valid_q[6] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_q[6];

	assign a_in = s_axis_tdata[QB-1:0];
	assign b_in = s_axis_tdata[2*QB-1:QB];

	// first pass right operand: b, or the pure vector of b for rotate
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			r1[i] = qmr_pkg::WCW'(b_in[i]);
		end
		if (s_axis_tuser[0] == qmr_pkg::CMD_ROTATE) begin
			r1[qmr_pkg::CW_IDX] = '0;
		end
	end

	qmr_hprod u_pass1 (
		.clk  (clk),
		.en   (en),
		.l    (a_in),
		.r    (r1),
		.o    (p),
		.clip (clip1)
	);

	// conjugate of a, held one bit wider so negation is exact
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			ac[i] = qmr_pkg::WCW'(a_s3[i]);
		end
		ac[qmr_pkg::CX] = -qmr_pkg::WCW'(a_s3[qmr_pkg::CX]);
		ac[qmr_pkg::CY] = -qmr_pkg::WCW'(a_s3[qmr_pkg::CY]);
		ac[qmr_pkg::CZ] = -qmr_pkg::WCW'(a_s3[qmr_pkg::CZ]);
	end

	qmr_hprod u_pass2 (
		.clk  (clk),
		.en   (en),
		.l    (p),
		.r    (ac),
		.o    (rot),
		.clip (clip2)
	);

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[5:1], s_axis_tvalid};
		end
	end

	// side payload: command, left operand, and first pass result
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= s_axis_tuser[0];
			cmd_s2   <= cmd_s1;
			cmd_s3   <= cmd_s2;
			cmd_s4   <= cmd_s3;
			cmd_s5   <= cmd_s4;
			cmd_s6   <= cmd_s5;
			a_s1     <= a_in;
			a_s2     <= a_s1;
			a_s3     <= a_s2;
			mul_s4   <= p;
			mul_s5   <= mul_s4;
			mul_s6   <= mul_s5;
			flag1_s4 <= |clip1;
			flag1_s5 <= flag1_s4;
			flag1_s6 <= flag1_s5;
		end
	end

	// output select; a rotate drops the final scalar and its clip
	always_comb begin
		if (cmd_s6 == qmr_pkg::CMD_ROTATE) begin
			res                   = rot;
			res[qmr_pkg::CW_IDX]  = '0;
			sat_out = flag1_s6 || clip2[qmr_pkg::CX] || clip2[qmr_pkg::CY]
				|| clip2[qmr_pkg::CZ];
		end else begin
			res     = mul_s6;
			sat_out = flag1_s6;
		end
	end

	assign m_axis_tdata    = res;
	assign m_axis_tuser[0] = sat_out;

	// an accepted word enters the first stage with its command
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_q[1] && cmd_s1 == $past(s_axis_tuser[0]))
		else $error("accepted word did not enter stage one");

	// a flagged multiply result holds at least one clipped component
	a_mul_clip: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[6] && cmd_s6 == qmr_pkg::CMD_MULTIPLY && m_axis_tuser[0] |->
			mul_s6[0] == {1'b0, {(qmr_pkg::CW-1){1'b1}}} ||
			mul_s6[0] == {1'b1, {(qmr_pkg::CW-1){1'b0}}} ||
			mul_s6[1] == {1'b0, {(qmr_pkg::CW-1){1'b1}}} ||
			mul_s6[1] == {1'b1, {(qmr_pkg::CW-1){1'b0}}} ||
			mul_s6[2] == {1'b0, {(qmr_pkg::CW-1){1'b1}}} ||
			mul_s6[2] == {1'b1, {(qmr_pkg::CW-1){1'b0}}} ||
			mul_s6[3] == {1'b0, {(qmr_pkg::CW-1){1'b1}}} ||
			mul_s6[3] == {1'b1, {(qmr_pkg::CW-1){1'b0}}})
		else $error("clip flag set on unclipped multiply result");

	// a held output word keeps its command and multiply payload
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[6] && !m_axis_tready |=> valid_q[6] && $stable(cmd_s6) && $stable(mul_s6))
		else $error("last stage changed while stalled");

endmodule
